// ===== src/lre_pkg.sv =====
// Package for the LR expression evaluator: sizes, codes, parse tables.
// Used by lre_alu and the top level in src; depends on nothing.
package lre_pkg;

	localparam int StackDepth = 32;
	localparam int ValueBits  = 32;
	localparam int PtrBits    = $clog2(StackDepth);
	localparam int DepthBits  = $clog2(StackDepth + 1);

	typedef logic [ValueBits-1:0] value_t;
	typedef logic [PtrBits-1:0]   ptr_t;
	typedef logic [DepthBits-1:0] depth_t;
	typedef logic [3:0]           pstate_t;

	// token kinds
	localparam logic [2:0] TK_NUM   = 3'd0;
	localparam logic [2:0] TK_PLUS  = 3'd1;
	localparam logic [2:0] TK_TIMES = 3'd2;
	localparam logic [2:0] TK_OPEN  = 3'd3;
	localparam logic [2:0] TK_CLOSE = 3'd4;
	localparam logic [2:0] TK_MINUS = 3'd5;
	localparam logic [2:0] TK_DIV   = 3'd6;
	localparam logic [2:0] TK_END   = 3'd7;

	// result status
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SYN  = 2'd1;
	localparam logic [1:0] ST_DIV0 = 2'd2;
	localparam logic [1:0] ST_OVF  = 2'd3;

	// action kinds
	typedef enum logic [1:0] {ACT_ERR, ACT_SHIFT, ACT_REDUCE, ACT_ACC} act_kind_t;

	typedef struct packed {
		act_kind_t  kind;
		logic [3:0] arg;
	} action_t;

	// arithmetic unit opcodes
	typedef enum logic [1:0] {ALU_ADD, ALU_SUB, ALU_MUL, ALU_DIV} alu_op_t;

	// sequencer states
	typedef enum logic [3:0] {
		S_IDLE, S_LOOK, S_RD_OPS, S_OPS, S_ALU, S_ALU_WAIT,
		S_POP, S_GOTO, S_ACC_RD, S_ACC, S_OUT
	} seq_state_t;

	// request / response between sequencer and arithmetic unit
	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic   done;
		logic   div0;
		value_t value;
	} alu_rsp_t;

	function automatic action_t sh(input logic [3:0] n);
		sh = '{ACT_SHIFT, n};
	endfunction
	function automatic action_t rd(input logic [3:0] n);
		rd = '{ACT_REDUCE, n};
	endfunction

	// SLR action table
	function automatic action_t action_lookup(input pstate_t s, input logic [2:0] k);
		action_t a;
		a = '{ACT_ERR, 4'd0};
		unique case (s)
			4'd0, 4'd4, 4'd6, 4'd7, 4'd8, 4'd9: begin
				if (k == TK_NUM) a = sh(4'd5);
				else if (k == TK_OPEN) a = sh(4'd4);
			end
			4'd1: begin
				if (k == TK_PLUS) a = sh(4'd6);
				else if (k == TK_MINUS) a = sh(4'd7);
				else if (k == TK_END) a = '{ACT_ACC, 4'd0};
			end
			4'd2, 4'd11, 4'd12: begin
				if (k == TK_TIMES) a = sh(4'd8);
				else if (k == TK_DIV) a = sh(4'd9);
				else if (k != TK_NUM && k != TK_OPEN)
					a = rd((s == 4'd2) ? 4'd3 : (s == 4'd11) ? 4'd1 : 4'd2);
			end
			4'd10: begin
				if (k == TK_PLUS) a = sh(4'd6);
				else if (k == TK_MINUS) a = sh(4'd7);
				else if (k == TK_CLOSE) a = sh(4'd15);
			end
			default: begin
				if (k != TK_NUM && k != TK_OPEN) begin
					case (s)
						4'd3:  a = rd(4'd6);
						4'd5:  a = rd(4'd8);
						4'd13: a = rd(4'd4);
						4'd14: a = rd(4'd5);
						4'd15: a = rd(4'd7);
						default: a = '{ACT_ERR, 4'd0};
					endcase
				end
			end
		endcase
		return a;
	endfunction

	// goto on E (0), T (1), F (2); zero means none
	function automatic pstate_t goto_lookup(input pstate_t s, input logic [1:0] lhs);
		pstate_t g;
		g = 4'd0;
		case (s)
			4'd0: g = (lhs == 2'd0) ? 4'd1 : (lhs == 2'd1) ? 4'd2 : 4'd3;
			4'd4: g = (lhs == 2'd0) ? 4'd10 : (lhs == 2'd1) ? 4'd2 : 4'd3;
			4'd6: g = (lhs == 2'd1) ? 4'd11 : (lhs == 2'd2) ? 4'd3 : 4'd0;
			4'd7: g = (lhs == 2'd1) ? 4'd12 : (lhs == 2'd2) ? 4'd3 : 4'd0;
			4'd8: g = (lhs == 2'd2) ? 4'd13 : 4'd0;
			4'd9: g = (lhs == 2'd2) ? 4'd14 : 4'd0;
			default: g = 4'd0;
		endcase
		return g;
	endfunction

	function automatic logic [1:0] rule_len(input logic [3:0] r);
		case (r)
			4'd1, 4'd2, 4'd4, 4'd5, 4'd7: rule_len = 2'd3;
			default: rule_len = 2'd1;
		endcase
	endfunction

	function automatic logic [1:0] rule_lhs(input logic [3:0] r);
		case (r)
			4'd4, 4'd5, 4'd6: rule_lhs = 2'd1;
			4'd7, 4'd8:       rule_lhs = 2'd2;
			default:          rule_lhs = 2'd0;
		endcase
	endfunction

endpackage

// ===== src/lre_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lre_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== src/lre_alu.sv =====
// Shared arithmetic unit: add, subtract, multiply with a registered result,
// signed truncating divide one quotient bit a cycle. Depends on lre_pkg.
module lre_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  lre_pkg::alu_req_t req,
	input  lre_pkg::value_t   lhs,
	input  lre_pkg::value_t   rhs,
	output lre_pkg::alu_rsp_t rsp
);
	localparam int CntBits = $clog2(lre_pkg::ValueBits + 1);

	logic                   busy_q;
	logic [CntBits-1:0]     cnt_q;
	lre_pkg::value_t        quo_q, rem_q, dvs_q;
	logic                   neg_q;
	logic                   done_q, div0_q;
	lre_pkg::value_t        res_q;
	logic [lre_pkg::ValueBits:0] trial;
	lre_pkg::value_t        rem_sh;
	lre_pkg::value_t        mag_a, mag_b;

	assign mag_a  = lhs[lre_pkg::ValueBits-1] ? (~lhs + 1'b1) : lhs;
	assign mag_b  = rhs[lre_pkg::ValueBits-1] ? (~rhs + 1'b1) : rhs;
	assign rem_sh = {rem_q[lre_pkg::ValueBits-2:0], quo_q[lre_pkg::ValueBits-1]};
	assign trial  = {1'b0, rem_sh} - {1'b0, dvs_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			div0_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			div0_q <= 1'b0;
			if (req.start && !busy_q) begin
				if (req.op == lre_pkg::ALU_DIV) begin
					if (rhs == '0) begin
						done_q <= 1'b1;
						div0_q <= 1'b1;
					end else begin
						busy_q <= 1'b1;
						cnt_q  <= CntBits'(lre_pkg::ValueBits);
					end
				end else begin
					done_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntBits'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			unique case (req.op)
				lre_pkg::ALU_ADD: res_q <= lhs + rhs;
				lre_pkg::ALU_SUB: res_q <= lhs - rhs;
				lre_pkg::ALU_MUL: res_q <= lhs * rhs;
				lre_pkg::ALU_DIV: res_q <= '0;
			endcase
			quo_q <= mag_a;
			rem_q <= '0;
			dvs_q <= mag_b;
			neg_q <= lhs[lre_pkg::ValueBits-1] ^ rhs[lre_pkg::ValueBits-1];
		end else if (busy_q) begin
			if (!trial[lre_pkg::ValueBits]) begin
				rem_q <= trial[lre_pkg::ValueBits-1:0];
				quo_q <= {quo_q[lre_pkg::ValueBits-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[lre_pkg::ValueBits-2:0], 1'b0};
			end
			if (cnt_q == CntBits'(1)) begin
				if (neg_q)
					res_q <= ~{quo_q[lre_pkg::ValueBits-2:0], !trial[lre_pkg::ValueBits]} + 1'b1;
				else
					res_q <= {quo_q[lre_pkg::ValueBits-2:0], !trial[lre_pkg::ValueBits]};
			end
		end
	end

	assign rsp = '{done: done_q, div0: div0_q, value: res_q};

	a_div0_only_div: assert property (@(posedge clk) disable iff (!arst_n)
		div0_q |-> done_q) else $error("div0 without done");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> !done_q || !busy_q) else $error("done while busy");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != '0) else $error("busy with zero count");
endmodule

// ===== src/lr_expression_evaluator.sv =====
// Top level of the LR expression evaluator: parse sequencer, both stacks, arithmetic unit.
// Depends on lre_pkg, lre_ram, lre_alu.
//
// Usage:
//  s_tuser carries the token kind and s_tdata its number value, one token a
//  beat. A plain shift goes from S_IDLE through S_LOOK and back to S_IDLE.
//  Each reduction walks S_LOOK, S_POP and S_GOTO; a fold by + - * / also
//  passes S_RD_OPS, S_OPS, S_ALU and S_ALU_WAIT, where a division waits on
//  the bit-serial divider inside the shared arithmetic unit. Accepting the
//  end token passes S_ACC_RD and S_ACC. The sequencer walks one table step
//  at a time, and s_tready is low while a token is being worked.
//  m_tdata carries a result when the end token is accepted or an error hits;
//  a shift that succeeds produces no beat. The result waits in an output
//  register until m_tready; a new token is not taken until it has gone.
//  The first token after a result is then taken at once.
//  Reset clears the stack depths (parse stack holds the start state) and
//  drops any token in flight; stack memories are not cleared since the parse
//  only reads entries it has written.
//  Each result, of any status, empties both stacks.
module lr_expression_evaluator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] number_value
	input  logic [2:0]  s_tuser,  // [2:0] token_kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [31:0] result_value
	output logic [1:0]  m_tuser   // [1:0] status
);
	localparam int VB = lre_pkg::ValueBits;

	lre_pkg::seq_state_t state_q, state_d;
	logic [2:0]          kind_q;
	lre_pkg::value_t     num_q;
	lre_pkg::depth_t     pdepth_q, odepth_q;
	lre_pkg::pstate_t    top_q;        // top of parse stack, kept in a register
	lre_pkg::action_t    act_q;
	lre_pkg::value_t     rhs_q;
	logic [31:0]         out_val_q;
	logic [1:0]          out_st_q;
	logic                out_valid_q;

	// parse stack ram
	logic             ps_we;
	lre_pkg::ptr_t    ps_waddr, ps_raddr;
	lre_pkg::pstate_t ps_wdata, ps_rdata;
	// operand stack ram
	logic             os_we;
	lre_pkg::ptr_t    os_waddr, os_raddr;
	lre_pkg::value_t  os_wdata, os_rdata;

	lre_pkg::alu_req_t alu_req;
	lre_pkg::alu_rsp_t alu_rsp;

	lre_pkg::action_t act_now;
	lre_pkg::pstate_t goto_now;
	lre_pkg::pstate_t goto_from;
	logic [1:0]       rlen;

	// register-next values
	lre_pkg::depth_t  pdepth_d, odepth_d;
	lre_pkg::pstate_t top_d;
	logic [31:0]      out_val_d;
	logic [1:0]       out_st_d;
	logic             emit;

	lre_ram #(.Width(4), .Depth(lre_pkg::StackDepth)) u_pstack (
		.clk, .we(ps_we), .waddr(ps_waddr), .wdata(ps_wdata),
		.raddr(ps_raddr), .rdata(ps_rdata)
	);

	lre_ram #(.Width(VB), .Depth(lre_pkg::StackDepth)) u_ostack (
		.clk, .we(os_we), .waddr(os_waddr), .wdata(os_wdata),
		.raddr(os_raddr), .rdata(os_rdata)
	);

	lre_alu u_alu (
		.clk, .arst_n, .req(alu_req), .lhs(os_rdata), .rhs(rhs_q), .rsp(alu_rsp)
	);

	// entry zero is the start state and is never written
	assign goto_from = (pdepth_q == lre_pkg::DepthBits'(1)) ? lre_pkg::pstate_t'(0) : ps_rdata;

	assign act_now  = lre_pkg::action_lookup(top_q, kind_q);
	assign rlen     = lre_pkg::rule_len(act_q.arg);
	assign goto_now = lre_pkg::goto_lookup(goto_from, lre_pkg::rule_lhs(act_q.arg));

	assign s_tready = (state_q == lre_pkg::S_IDLE) && !out_valid_q;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_val_q;
	assign m_tuser  = out_st_q;

	// state register and stack depths
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lre_pkg::S_IDLE;
			pdepth_q    <= lre_pkg::DepthBits'(1);
			odepth_q    <= '0;
			top_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			pdepth_q <= pdepth_d;
			odepth_q <= odepth_d;
			top_q    <= top_d;
			if (emit) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_q <= s_tuser;
			num_q  <= VB'($signed(s_tdata));
		end
		if (state_q == lre_pkg::S_LOOK) act_q <= act_now;
		if (state_q == lre_pkg::S_OPS) rhs_q <= os_rdata;
		if (emit) begin
			out_val_q <= out_val_d;
			out_st_q  <= out_st_d;
		end
	end

	// sequencer
	always_comb begin
		state_d   = state_q;
		pdepth_d  = pdepth_q;
		odepth_d  = odepth_q;
		top_d     = top_q;
		emit      = 1'b0;
		out_val_d = '0;
		out_st_d  = lre_pkg::ST_SYN;
		ps_we     = 1'b0;
		ps_waddr  = pdepth_q[lre_pkg::PtrBits-1:0];
		ps_wdata  = act_q.arg;
		ps_raddr  = '0;
		os_we     = 1'b0;
		os_waddr  = odepth_q[lre_pkg::PtrBits-1:0];
		os_wdata  = num_q;
		os_raddr  = lre_pkg::PtrBits'(odepth_q - 1'b1);
		alu_req   = '{start: 1'b0, op: lre_pkg::ALU_ADD};
		unique case (state_q)
			lre_pkg::S_IDLE: begin
				if (s_tvalid && s_tready) state_d = lre_pkg::S_LOOK;
			end
			lre_pkg::S_LOOK: begin
				unique case (act_now.kind)
					lre_pkg::ACT_SHIFT: begin
						if (pdepth_q >= lre_pkg::DepthBits'(lre_pkg::StackDepth) ||
						    (kind_q == lre_pkg::TK_NUM &&
						     odepth_q >= lre_pkg::DepthBits'(lre_pkg::StackDepth))) begin
							out_st_d = lre_pkg::ST_OVF;
							state_d  = lre_pkg::S_OUT;
						end else begin
							ps_we    = 1'b1;
							ps_wdata = act_now.arg;
							pdepth_d = pdepth_q + 1'b1;
							top_d    = act_now.arg;
							if (kind_q == lre_pkg::TK_NUM) begin
								os_we    = 1'b1;
								odepth_d = odepth_q + 1'b1;
							end
							state_d = lre_pkg::S_IDLE;
						end
					end
					lre_pkg::ACT_REDUCE: begin
						if (act_now.arg == 4'd1 || act_now.arg == 4'd2 ||
						    act_now.arg == 4'd4 || act_now.arg == 4'd5) begin
							if (odepth_q < lre_pkg::DepthBits'(2)) begin
								state_d = lre_pkg::S_OUT;
							end else begin
								state_d = lre_pkg::S_RD_OPS;
							end
						end else begin
							state_d = lre_pkg::S_POP;
						end
					end
					lre_pkg::ACT_ACC: begin
						state_d = (odepth_q == '0) ? lre_pkg::S_OUT : lre_pkg::S_ACC_RD;
					end
					default: state_d = lre_pkg::S_OUT;
				endcase
			end
			lre_pkg::S_RD_OPS: begin
				// read right operand
				state_d = lre_pkg::S_OPS;
			end
			lre_pkg::S_OPS: begin
				// right operand arrives; read left
				os_raddr = lre_pkg::PtrBits'(odepth_q - 2'd2);
				state_d  = lre_pkg::S_ALU;
			end
			lre_pkg::S_ALU: begin
				alu_req.start = 1'b1;
				case (act_q.arg)
					4'd1:    alu_req.op = lre_pkg::ALU_ADD;
					4'd2:    alu_req.op = lre_pkg::ALU_SUB;
					4'd4:    alu_req.op = lre_pkg::ALU_MUL;
					default: alu_req.op = lre_pkg::ALU_DIV;
				endcase
				state_d = lre_pkg::S_ALU_WAIT;
			end
			lre_pkg::S_ALU_WAIT: begin
				os_raddr = lre_pkg::PtrBits'(odepth_q - 2'd2);
				if (alu_rsp.done) begin
					if (alu_rsp.div0) begin
						out_st_d = lre_pkg::ST_DIV0;
						state_d  = lre_pkg::S_OUT;
					end else begin
						os_we    = 1'b1;
						os_waddr = lre_pkg::PtrBits'(odepth_q - 2'd2);
						os_wdata = alu_rsp.value;
						odepth_d = odepth_q - 1'b1;
						state_d  = lre_pkg::S_POP;
					end
				end
			end
			lre_pkg::S_POP: begin
				if (pdepth_q <= lre_pkg::DepthBits'(rlen)) begin
					state_d = lre_pkg::S_OUT;
				end else begin
					pdepth_d = pdepth_q - lre_pkg::DepthBits'(rlen);
					ps_raddr = lre_pkg::PtrBits'(pdepth_q - lre_pkg::DepthBits'(rlen) - 1'b1);
					state_d  = lre_pkg::S_GOTO;
				end
			end
			lre_pkg::S_GOTO: begin
				if (goto_now == '0) begin
					state_d = lre_pkg::S_OUT;
				end else begin
					ps_we    = 1'b1;
					ps_wdata = goto_now;
					pdepth_d = pdepth_q + 1'b1;
					top_d    = goto_now;
					state_d  = lre_pkg::S_LOOK;
				end
			end
			lre_pkg::S_ACC_RD: begin
				state_d = lre_pkg::S_ACC;
			end
			lre_pkg::S_ACC: begin
				emit      = 1'b1;
				out_st_d  = lre_pkg::ST_OK;
				out_val_d = 32'($signed(os_rdata));
				pdepth_d  = lre_pkg::DepthBits'(1);
				odepth_d  = '0;
				top_d     = '0;
				state_d   = lre_pkg::S_IDLE;
			end
			lre_pkg::S_OUT: begin
				emit     = 1'b1;
				out_st_d = (act_q.kind == lre_pkg::ACT_SHIFT) ? lre_pkg::ST_OVF :
				           (act_q.kind == lre_pkg::ACT_REDUCE && act_q.arg == 4'd5 &&
				            rhs_q == '0 && odepth_q >= lre_pkg::DepthBits'(2)) ?
				           lre_pkg::ST_DIV0 : lre_pkg::ST_SYN;
				pdepth_d = lre_pkg::DepthBits'(1);
				odepth_d = '0;
				top_d    = '0;
				state_d  = lre_pkg::S_IDLE;
			end
			default: state_d = lre_pkg::S_IDLE;
		endcase
	end

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pdepth_q <= lre_pkg::DepthBits'(lre_pkg::StackDepth) && pdepth_q != '0)
		else $error("parse depth out of range");
	a_result_resets: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> pdepth_q == lre_pkg::DepthBits'(1) && odepth_q == '0)
		else $error("stacks not reset after result");
	a_no_emit_pending: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> !out_valid_q) else $error("result overwrote pending beat");
	a_ok_value_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_st_q != lre_pkg::ST_OK |-> out_val_q == '0)
		else $error("nonzero value on error status");
endmodule

// ===== tb/lre_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the LR expression evaluator: watches both stream channels,
// runs its own shift-reduce predictor on each token beat and checks result beats.
// Depends on lre_pkg for token and status codes.
module lre_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] number_value
	input  logic [2:0]  s_tuser,  // [2:0] token_kind
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,  // [31:0] result_value
	input  logic [1:0]  m_tuser,  // [1:0] status
	output int          fail_count,
	output int          pending,
	output int          result_count
);

	typedef enum logic [1:0] {STEP_ERR, STEP_SHIFT, STEP_REDUCE, STEP_ACCEPT} step_kind_t;

	typedef struct packed {
		step_kind_t kind;
		logic [3:0] arg;
	} step_t;

	typedef struct packed {
		logic [31:0] value;
		logic [1:0]  status;
	} outcome_t;

	outcome_t    outcome_q[$];
	logic [3:0]  state_stk[32];
	logic [31:0] operand_stk[32];
	int          state_depth;
	int          operand_depth;

	assign pending = outcome_q.size();

	// SLR action for a parse state and a token kind
	function automatic step_t next_step(input logic [3:0] s, input logic [2:0] k);
		step_t a;
		logic  reduces;
		a = '{STEP_ERR, 4'd0};
		reduces = (k != lre_pkg::TK_NUM) && (k != lre_pkg::TK_OPEN);
		case (s)
			4'd0, 4'd4, 4'd6, 4'd7, 4'd8, 4'd9: begin
				if (k == lre_pkg::TK_NUM) a = '{STEP_SHIFT, 4'd5};
				if (k == lre_pkg::TK_OPEN) a = '{STEP_SHIFT, 4'd4};
			end
			4'd1: begin
				if (k == lre_pkg::TK_PLUS) a = '{STEP_SHIFT, 4'd6};
				if (k == lre_pkg::TK_MINUS) a = '{STEP_SHIFT, 4'd7};
				if (k == lre_pkg::TK_END) a = '{STEP_ACCEPT, 4'd0};
			end
			4'd2, 4'd11, 4'd12: begin
				if (reduces)
					a = '{STEP_REDUCE, (s == 4'd2) ? 4'd3 : (s == 4'd11) ? 4'd1 : 4'd2};
				if (k == lre_pkg::TK_TIMES) a = '{STEP_SHIFT, 4'd8};
				if (k == lre_pkg::TK_DIV) a = '{STEP_SHIFT, 4'd9};
			end
			4'd10: begin
				if (k == lre_pkg::TK_PLUS) a = '{STEP_SHIFT, 4'd6};
				if (k == lre_pkg::TK_MINUS) a = '{STEP_SHIFT, 4'd7};
				if (k == lre_pkg::TK_CLOSE) a = '{STEP_SHIFT, 4'd15};
			end
			4'd3:  if (reduces) a = '{STEP_REDUCE, 4'd6};
			4'd5:  if (reduces) a = '{STEP_REDUCE, 4'd8};
			4'd13: if (reduces) a = '{STEP_REDUCE, 4'd4};
			4'd14: if (reduces) a = '{STEP_REDUCE, 4'd5};
			default: if (reduces) a = '{STEP_REDUCE, 4'd7};
		endcase
		return a;
	endfunction

	// goto on E (0), T (1), F (2); zero means none
	function automatic logic [3:0] goto_state(input logic [3:0] s, input int lhs);
		case (s)
			4'd0: return (lhs == 0) ? 4'd1 : (lhs == 1) ? 4'd2 : 4'd3;
			4'd4: return (lhs == 0) ? 4'd10 : (lhs == 1) ? 4'd2 : 4'd3;
			4'd6: return (lhs == 1) ? 4'd11 : (lhs == 2) ? 4'd3 : 4'd0;
			4'd7: return (lhs == 1) ? 4'd12 : (lhs == 2) ? 4'd3 : 4'd0;
			4'd8: return (lhs == 2) ? 4'd13 : 4'd0;
			4'd9: return (lhs == 2) ? 4'd14 : 4'd0;
			default: return 4'd0;
		endcase
	endfunction

	task automatic clear_stacks();
		state_stk[0] = 4'd0;
		state_depth = 1;
		operand_depth = 0;
	endtask

	task automatic post_outcome(input logic [31:0] v, input logic [1:0] st);
		outcome_q.push_back('{v, st});
		clear_stacks();
	endtask

	// run one token through the parser, queueing a result if one comes out
	task automatic evaluate_token(input logic [2:0] kind, input logic [31:0] num);
		step_t       a;
		int          len;
		int          lhs;
		logic [31:0] l, r, v;
		logic [3:0]  g;
		longint      q;
		for (int guard = 0; guard < 144; guard++) begin
			a = next_step(state_stk[state_depth-1], kind);
			case (a.kind)
				STEP_SHIFT: begin
					if (state_depth >= 32 ||
					    (kind == lre_pkg::TK_NUM && operand_depth >= 32)) begin
						post_outcome('0, lre_pkg::ST_OVF);
						return;
					end
					if (kind == lre_pkg::TK_NUM) begin
						operand_stk[operand_depth] = num;
						operand_depth++;
					end
					state_stk[state_depth] = a.arg;
					state_depth++;
					return;
				end
				STEP_REDUCE: begin
					len = (a.arg inside {4'd1, 4'd2, 4'd4, 4'd5, 4'd7}) ? 3 : 1;
					lhs = (a.arg inside {4'd4, 4'd5, 4'd6}) ? 1 :
					      (a.arg inside {4'd7, 4'd8}) ? 2 : 0;
					if (a.arg inside {4'd1, 4'd2, 4'd4, 4'd5}) begin
						if (operand_depth < 2) begin
							post_outcome('0, lre_pkg::ST_SYN);
							return;
						end
						r = operand_stk[operand_depth-1];
						l = operand_stk[operand_depth-2];
						case (a.arg)
							4'd1: v = l + r;
							4'd2: v = l - r;
							4'd4: v = l * r;
							default: begin
								if (r == 0) begin
									post_outcome('0, lre_pkg::ST_DIV0);
									return;
								end
								// 64-bit quotient so min / -1 wraps cleanly
								q = longint'($signed(l)) / longint'($signed(r));
								v = q[31:0];
							end
						endcase
						operand_depth--;
						operand_stk[operand_depth-1] = v;
					end
					if (state_depth <= len) begin
						post_outcome('0, lre_pkg::ST_SYN);
						return;
					end
					state_depth -= len;
					g = goto_state(state_stk[state_depth-1], lhs);
					if (g == 0) begin
						post_outcome('0, lre_pkg::ST_SYN);
						return;
					end
					state_stk[state_depth] = g;
					state_depth++;
				end
				STEP_ACCEPT: begin
					if (operand_depth == 0) post_outcome('0, lre_pkg::ST_SYN);
					else post_outcome(operand_stk[operand_depth-1], lre_pkg::ST_OK);
					return;
				end
				default: begin
					post_outcome('0, lre_pkg::ST_SYN);
					return;
				end
			endcase
		end
		post_outcome('0, lre_pkg::ST_SYN);
	endtask

	// compare result beats first, then predict from the token beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_stacks();
			outcome_q.delete();
			fail_count = 0;
			result_count = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				result_count++;
				if (outcome_q.size() == 0) begin
					$error("unexpected result beat: value %0d status %0d",
						$signed(m_tdata), m_tuser);
					fail_count++;
				end else begin
					if (m_tdata !== outcome_q[0].value) begin
						$error("result_value: expected %0d, got %0d",
							$signed(outcome_q[0].value), $signed(m_tdata));
						fail_count++;
					end
					if (m_tuser !== outcome_q[0].status) begin
						$error("status: expected %0d, got %0d",
							outcome_q[0].status, m_tuser);
						fail_count++;
					end
					void'(outcome_q.pop_front());
				end
			end
			if (s_tvalid && s_tready)
				evaluate_token(s_tuser, s_tdata);
		end
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the LR expression evaluator: clock, reset, token stimulus,
// result back-pressure, watchdog and verdict. Depends on lre_pkg, lr_expression_evaluator, lre_checker.
module tb;

	localparam int NumItems   = 1700;
	localparam int QuietItems = 1500;
	localparam int StallLimit = 20000;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] num;
	} token_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	int          fail_count;
	int          pending;
	int          result_count;
	int          beats_sent;
	int          stall_cycles;
	int          ready_hold;
	bit          quiet;
	bit          drained;
	token_t      token_q[$];

	lr_expression_evaluator dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	lre_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.fail_count(fail_count), .pending(pending), .result_count(result_count)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// result side back-pressure in bursts
	always @(posedge clk) begin
		if (quiet) begin
			m_tready <= 1'b1;
		end else if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			ready_hold <= $urandom_range(0, 8);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= StallLimit) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	function automatic logic [31:0] pick_number();
		case ($urandom_range(0, 15))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return 32'd0;
			4, 5, 6: return $urandom;
			default: return $urandom_range(1, 40) - 12;
		endcase
	endfunction

	task automatic push_tok(input logic [2:0] k, input logic [31:0] n);
		token_q.push_back('{k, n});
	endtask

	// random well-formed expression of the E/T/F grammar
	task automatic gen_factor(input int depth);
		if (depth > 0 && $urandom_range(0, 3) == 0) begin
			push_tok(lre_pkg::TK_OPEN, $urandom);
			gen_expr(depth - 1);
			push_tok(lre_pkg::TK_CLOSE, $urandom);
		end else begin
			push_tok(lre_pkg::TK_NUM, pick_number());
		end
	endtask

	task automatic gen_term(input int depth);
		gen_factor(depth);
		repeat ($urandom_range(0, 2)) begin
			push_tok($urandom_range(0, 1) ? lre_pkg::TK_TIMES : lre_pkg::TK_DIV, $urandom);
			gen_factor(depth);
		end
	endtask

	task automatic gen_expr(input int depth);
		gen_term(depth);
		repeat ($urandom_range(0, 2)) begin
			push_tok($urandom_range(0, 1) ? lre_pkg::TK_PLUS : lre_pkg::TK_MINUS, $urandom);
			gen_term(depth);
		end
	endtask

	// drive every queued token, idling in bursts between some beats unless quiet
	task automatic drive_tokens();
		token_t t;
		while (token_q.size() > 0) begin
			t = token_q.pop_front();
			if (!quiet && $urandom_range(0, 4) == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata <= t.num;
			s_tuser <= t.kind;
			do @(posedge clk); while (!s_tready);
			beats_sent++;
		end
		s_tvalid <= 1'b0;
	endtask

	initial begin
		int mode;
		int pos;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		ready_hold = 0;
		quiet = 1'b0;
		drained = 1'b0;
		beats_sent = 0;
		stall_cycles = 0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: each operator, extremes, error cases
		push_tok(lre_pkg::TK_NUM, 32'h7fff_ffff); push_tok(lre_pkg::TK_PLUS, 0);
		push_tok(lre_pkg::TK_NUM, 1); push_tok(lre_pkg::TK_END, 0);
		push_tok(lre_pkg::TK_NUM, 32'h8000_0000); push_tok(lre_pkg::TK_DIV, 0);
		push_tok(lre_pkg::TK_NUM, 32'hffff_ffff); push_tok(lre_pkg::TK_END, 0);
		push_tok(lre_pkg::TK_OPEN, 0); push_tok(lre_pkg::TK_NUM, 7);
		push_tok(lre_pkg::TK_MINUS, 0); push_tok(lre_pkg::TK_NUM, 32'h8000_0000);
		push_tok(lre_pkg::TK_CLOSE, 0); push_tok(lre_pkg::TK_TIMES, 0);
		push_tok(lre_pkg::TK_NUM, -3); push_tok(lre_pkg::TK_END, 0);
		push_tok(lre_pkg::TK_NUM, -7); push_tok(lre_pkg::TK_DIV, 0);
		push_tok(lre_pkg::TK_NUM, 2); push_tok(lre_pkg::TK_END, 0);
		// divide by zero, end on an empty stack, stray close paren
		push_tok(lre_pkg::TK_NUM, 5); push_tok(lre_pkg::TK_DIV, 0);
		push_tok(lre_pkg::TK_NUM, 0); push_tok(lre_pkg::TK_END, 0);
		push_tok(lre_pkg::TK_END, 0);
		push_tok(lre_pkg::TK_CLOSE, 0);
		drive_tokens();
		// parse stack overflow from deep nesting
		repeat (33) push_tok(lre_pkg::TK_OPEN, 32'hffff_ffff);
		push_tok(lre_pkg::TK_NUM, 0); push_tok(lre_pkg::TK_END, 0);
		drive_tokens();

		// random: mostly well-formed expressions, some corrupted, some noise
		while (beats_sent < NumItems) begin
			if (beats_sent >= QuietItems) quiet = 1'b1;
			mode = $urandom_range(0, 99);
			if (mode < 70) begin
				gen_expr($urandom_range(0, 3));
				push_tok(lre_pkg::TK_END, $urandom);
			end else if (mode < 85) begin
				gen_expr($urandom_range(0, 3));
				push_tok(lre_pkg::TK_END, $urandom);
				pos = $urandom_range(0, token_q.size() - 1);
				token_q[pos] = '{3'($urandom_range(0, 7)), $urandom};
			end else if (mode < 97) begin
				repeat ($urandom_range(1, 6)) push_tok(3'($urandom_range(0, 7)), $urandom);
			end else begin
				repeat ($urandom_range(28, 34)) push_tok(lre_pkg::TK_OPEN, $urandom);
				push_tok(lre_pkg::TK_NUM, pick_number());
				push_tok(lre_pkg::TK_END, $urandom);
			end
			drive_tokens();
			// one hold-off until the result side has fully drained
			if (beats_sent >= NumItems / 2 && !drained) begin
				drained = 1'b1;
				while (pending != 0) @(posedge clk);
			end
		end

		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("tb: %0d token beats and %0d result beats checked, covering",
			beats_sent, result_count);
		$display("tb: all operators, syntax errors, divide by zero and stack overflow");
		if (fail_count == 0 && pending == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule
